/* hdl/mrtu_pkg.sv */
package mrtu_pkg;

    localparam int CMD_W      = 2;
    localparam int BYTE_W     = 8;
    localparam int TIME_W     = 32;
    localparam int STS_W      = 2;
    localparam int CNT_W      = 7;
    localparam int GAP_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [GAP_W-1:0] GAP_RESET = 16'd4;
    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [CMD_W-1:0] {
        CMD_BYTE    = 2'd0,
        CMD_POLL    = 2'd1,
        CMD_DISCARD = 2'd2
    } t_cmd;

    typedef enum logic [STS_W-1:0] {
        STS_NONE  = 2'd0,
        STS_OVF   = 2'd1,
        STS_FRAME = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAP = 1'd0,
        CFG_CAP = 1'd1
    } t_cfg_idx;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_STREAM = 1'b1
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic byte_wr;
        logic clear;
        logic load_single;
        logic single_ovf;
        logic rd_start;
        logic rd_next;
        logic load_byte;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_byte;
        logic is_poll;
        logic is_discard;
        logic frame_done;
        logic frame_ovf;
        logic frame_empty;
        logic rd_last;
    } t_dp_sts;

endpackage

/* hdl/mrtu_stream_if.sv */
interface mrtu_in_if;
    import mrtu_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] rx_byte;
    logic [TIME_W-1:0] now_time;

    modport source (output valid, output command, output rx_byte, output now_time,
                    input ready);
    modport sink   (input valid, input command, input rx_byte, input now_time,
                    output ready);
endinterface

interface mrtu_out_if;
    import mrtu_pkg::*;

    logic              valid;
    logic              ready;
    logic [STS_W-1:0]  status;
    logic [BYTE_W-1:0] frame_byte;
    logic [CNT_W-1:0]  frame_len;
    logic              last;

    modport source (output valid, output status, output frame_byte, output frame_len,
                    output last, input ready);
    modport sink   (input valid, input status, input frame_byte, input frame_len,
                    input last, output ready);
endinterface

/* hdl/mrtu_ram.sv */
module mrtu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* hdl/mrtu_datapath.sv */
module mrtu_datapath #(
    parameter int MAX_FRAME = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mrtu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mrtu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [mrtu_pkg::CMD_W-1:0]      i_command,
    input  logic [mrtu_pkg::BYTE_W-1:0]     i_rx_byte,
    input  logic [mrtu_pkg::TIME_W-1:0]     i_now_time,
    input  mrtu_pkg::t_dp_cmd               i_cmd,
    output mrtu_pkg::t_dp_sts               o_sts,
    output logic [mrtu_pkg::STS_W-1:0]      o_status,
    output logic [mrtu_pkg::BYTE_W-1:0]     o_frame_byte,
    output logic [mrtu_pkg::CNT_W-1:0]      o_frame_len,
    output logic                            o_last
);
    import mrtu_pkg::*;

    localparam int AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME);

    logic [CNT_W-1:0]  r_count,  n_count;
    logic [TIME_W-1:0] r_arrival, n_arrival;
    logic              r_active, n_active;
    logic              r_ovf,    n_ovf;
    logic [GAP_W-1:0]  r_gap;
    logic [CNT_W-1:0]  r_cap;
    logic [AW-1:0]     r_idx,    n_idx;

    logic [STS_W-1:0]  r_status;
    logic [BYTE_W-1:0] r_byte;
    logic [CNT_W-1:0]  r_len;
    logic              r_last;

    logic              store_ok;
    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;
    logic [TIME_W-1:0] elapsed;
    logic              rd_last;

    assign store_ok  = r_count < MAX_CNT;
    assign ram_we    = i_cmd.byte_wr && store_ok;
    assign ram_re    = i_cmd.rd_start || i_cmd.rd_next;
    assign ram_raddr = i_cmd.rd_start ? '0 : r_idx + AW'(1);
    assign elapsed   = i_now_time - r_arrival;
    assign rd_last   = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;

    mrtu_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_FRAME)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_sts.is_byte     = i_command == CMD_BYTE;
        o_sts.is_poll     = i_command == CMD_POLL;
        o_sts.is_discard  = i_command == CMD_DISCARD;
        o_sts.frame_done  = r_active && (elapsed >= TIME_W'(r_gap));
        o_sts.frame_ovf   = r_ovf || (r_count > r_cap);
        o_sts.frame_empty = r_count == '0;
        o_sts.rd_last     = rd_last;
    end

    always_comb begin
        n_count   = r_count;
        n_arrival = r_arrival;
        n_active  = r_active;
        n_ovf     = r_ovf;
        n_idx     = r_idx;
        if (i_cmd.byte_wr) begin
            if (store_ok) begin
                n_count = r_count + CNT_W'(1);
            end else begin
                n_ovf = 1'b1;
            end
            n_arrival = i_now_time;
            n_active  = 1'b1;
        end
        if (i_cmd.clear) begin
            n_count   = '0;
            n_arrival = '0;
            n_active  = 1'b0;
            n_ovf     = 1'b0;
        end
        if (i_cmd.rd_start) begin
            n_idx = '0;
        end else if (i_cmd.rd_next) begin
            n_idx = r_idx + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_arrival <= '0;
            r_active  <= 1'b0;
            r_ovf     <= 1'b0;
            r_gap     <= GAP_RESET;
            r_cap     <= CAP_RESET;
        end else begin
            r_count   <= n_count;
            r_arrival <= n_arrival;
            r_active  <= n_active;
            r_ovf     <= n_ovf;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_GAP: r_gap <= i_cfg_data[GAP_W-1:0];
                    CFG_CAP: r_cap <= i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.load_single) begin
            r_status <= i_cmd.single_ovf ? STS_OVF : STS_NONE;
            r_byte   <= '0;
            r_len    <= '0;
            r_last   <= 1'b1;
        end else if (i_cmd.load_byte) begin
            r_status <= STS_FRAME;
            r_byte   <= ram_rdata;
            r_len    <= r_count;
            r_last   <= rd_last;
        end
    end

    assign o_status     = r_status;
    assign o_frame_byte = r_byte;
    assign o_frame_len  = r_len;
    assign o_last       = r_last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("byte count beyond store depth");

    a_read_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_next |-> (CNT_W'(r_idx) + CNT_W'(1)) < r_count)
        else $error("store read past frame end");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_count == '0) && !r_active && !r_ovf)
        else $error("receiver not cleared");
`endif
endmodule

/* hdl/mrtu_ctrl.sv */
module mrtu_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  mrtu_pkg::t_dp_sts i_sts,
    output mrtu_pkg::t_dp_cmd o_cmd
);
    import mrtu_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;
    logic   accept;
    logic   deliver;

    assign slot_free = !r_out_valid || i_out_ready;
    assign deliver   = i_sts.frame_done && !i_sts.frame_ovf && !i_sts.frame_empty;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.rd_start) begin
                    n_state = ST_STREAM;
                end
            end
            ST_STREAM: begin
                if (slot_free && i_sts.rd_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        accept     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready        = slot_free;
                accept            = i_in_valid && slot_free;
                o_cmd.byte_wr     = accept && i_sts.is_byte;
                o_cmd.clear       = accept && (i_sts.is_discard || (i_sts.is_poll
                                    && i_sts.frame_done
                                    && (i_sts.frame_ovf || i_sts.frame_empty)));
                o_cmd.load_single = accept && i_sts.is_poll && !deliver;
                o_cmd.single_ovf  = i_sts.frame_done && i_sts.frame_ovf;
                o_cmd.rd_start    = accept && i_sts.is_poll && deliver;
            end
            ST_STREAM: begin
                o_cmd.load_byte = slot_free;
                o_cmd.rd_next   = slot_free && !i_sts.rd_last;
                o_cmd.clear     = slot_free && i_sts.rd_last;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_single || o_cmd.load_byte) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_stream_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STREAM) |-> !o_in_ready)
        else $error("input taken during frame stream");

    a_stream_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_start |=> (r_state == ST_STREAM) && !r_out_valid)
        else $error("stream start with output slot busy");

    a_stream_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STREAM && slot_free && i_sts.rd_last)
        |=> (r_state == ST_IDLE) && r_out_valid)
        else $error("final frame byte not delivered");
`endif
endmodule

/* hdl/modbus_rtu_frame_gap_receiver.sv */
// Byte and discard transactions: no result; the next input can be taken the cycle after.
// Poll without a deliverable frame: one result, registered in the cycle after acceptance.
// Poll with a frame of N bytes: first byte through the registered store read and then the
// output register, then one per cycle while the sink is ready; ready is low while it streams.
// Reset: synchronous, active low; clears receiver state and output valid, loads gap 4 and
// capacity 64. The frame store is not cleared. A waiting result holds input off.
module modbus_rtu_frame_gap_receiver #(
    parameter int MAX_FRAME = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mrtu_in_if.sink                         i_in,
    mrtu_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [mrtu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mrtu_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mrtu_pkg::*;

    // Controller sequences transactions; datapath owns the receiver state,
    // the frame store and the output register.
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    mrtu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    // Gap check: elapsed time is taken modulo 2^32 against the gap register.
    mrtu_datapath #(
        .MAX_FRAME (MAX_FRAME)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_command    (i_in.command),
        .i_rx_byte    (i_in.rx_byte),
        .i_now_time   (i_in.now_time),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .o_status     (o_out.status),
        .o_frame_byte (o_out.frame_byte),
        .o_frame_len  (o_out.frame_len),
        .o_last       (o_out.last)
    );
endmodule

/* dv/modbus_rtu_frame_gap_receiver_tb.sv */
`timescale 1ns / 1ps

module modbus_rtu_frame_gap_receiver_tb;
    import mrtu_pkg::*;

    localparam int MAX_FRAME   = 64;
    localparam int HOLD_CYCLES = 150;   // long receiver hold-off, backs the block up
    localparam int DRAIN_EXTRA = 4;     // poll-to-first-byte latency plus margin
    localparam int DRAIN_LIMIT = 20000;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_ITEMS = 20;

    // Command code the block must ignore.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // One result transaction as seen on the output channel.
    typedef struct {
        t_status            status;
        logic [BYTE_W-1:0]  fbyte;
        logic [CNT_W-1:0]   flen;
        logic               last;
    } t_rx_result;

    // Directed stimulus row. Rows with typed set carry their single
    // expected result; the rest are scored against the predictor.
    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] b;
        logic [TIME_W-1:0] t;
        int                reps;    // byte rows: repeated with b+i
        bit                typed;
        t_status           st;
    } t_dir_row;

    localparam int DIR_ROWS = 18;

    // Runs at reset settings: gap 4 ms, capacity 64.
    t_dir_row dir_tab [DIR_ROWS] = '{
        '{CMD_POLL,    8'h00, 32'd0,         1,  1'b1, STS_NONE},  // idle after reset
        '{CMD_BYTE,    8'h00, 32'd100,       1,  1'b0, STS_NONE},
        '{CMD_POLL,    8'h00, 32'd103,       1,  1'b1, STS_NONE},  // gap not reached
        '{CMD_BYTE,    8'hFF, 32'd104,       1,  1'b0, STS_NONE},
        '{CMD_POLL,    8'hFF, 32'd108,       1,  1'b0, STS_NONE},  // two-byte frame
        '{CMD_UNUSED,  8'h5A, 32'd200,       1,  1'b0, STS_NONE},  // ignored
        '{CMD_POLL,    8'h00, 32'd200,       1,  1'b1, STS_NONE},  // cleared by delivery
        '{CMD_BYTE,    8'hA5, 32'hFFFF_FFFE, 1,  1'b0, STS_NONE},
        '{CMD_POLL,    8'h00, 32'd2,         1,  1'b0, STS_NONE},  // gap across wrap
        '{CMD_BYTE,    8'h5A, 32'd10,        1,  1'b0, STS_NONE},
        '{CMD_DISCARD, 8'hFF, 32'd11,        1,  1'b0, STS_NONE},
        '{CMD_POLL,    8'h00, 32'd1000,      1,  1'b1, STS_NONE},  // discarded frame
        '{CMD_BYTE,    8'h01, 32'd500,       65, 1'b0, STS_NONE},  // store full, last drops
        '{CMD_POLL,    8'h00, 32'd504,       1,  1'b1, STS_OVF},
        '{CMD_POLL,    8'h00, 32'd600,       1,  1'b1, STS_NONE},  // cleared by overflow
        '{CMD_BYTE,    8'h3C, 32'hFFFF_FFFF, 1,  1'b0, STS_NONE},
        '{CMD_POLL,    8'h00, 32'h8000_0000, 1,  1'b0, STS_NONE},  // huge elapsed time
        '{CMD_POLL,    8'hFF, 32'hFFFF_FFFF, 1,  1'b1, STS_NONE}
    };

    logic i_clk;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mrtu_in_if  in_if ();
    mrtu_out_if out_if ();

    modbus_rtu_frame_gap_receiver #(
        .MAX_FRAME (MAX_FRAME)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Predictor state: receiver and its two registers.
    logic [BYTE_W-1:0] rx_store [MAX_FRAME];
    logic [CNT_W-1:0]  rx_count;
    logic [TIME_W-1:0] rx_last_t;
    bit                rx_active;
    bit                rx_ovf;
    logic [GAP_W-1:0]  gap_ms;
    logic [CNT_W-1:0]  cap_len;

    t_rx_result poll_res [$];     // results of the item just accepted
    t_rx_result rx_expect [$];    // results still owed by the block

    int errors;
    int items_sent;
    bit idle_en;
    bit hold_req;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic void rx_clear();
        rx_count  = '0;
        rx_last_t = '0;
        rx_active = 1'b0;
        rx_ovf    = 1'b0;
    endfunction

    function automatic void push_res(t_status st, logic [BYTE_W-1:0] b,
                                     logic [CNT_W-1:0] len, logic fin);
        t_rx_result r;
        r.status = st;
        r.fbyte  = b;
        r.flen   = len;
        r.last   = fin;
        poll_res.push_back(r);
    endfunction

    // Receiver behavior for one accepted item; fills poll_res.
    function automatic void rx_predict(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] b,
                                       logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] dt;
        poll_res.delete();
        dt = now - rx_last_t;
        case (cmd)
            CMD_BYTE: begin
                if (rx_count < MAX_FRAME) begin
                    rx_store[rx_count] = b;
                    rx_count++;
                end else begin
                    rx_ovf = 1'b1;
                end
                rx_last_t = now;
                rx_active = 1'b1;
            end
            CMD_DISCARD: rx_clear();
            CMD_POLL: begin
                if (!rx_active || dt < gap_ms) begin
                    push_res(STS_NONE, '0, '0, 1'b1);
                end else if (rx_ovf || cap_len < rx_count) begin
                    push_res(STS_OVF, '0, '0, 1'b1);
                    rx_clear();
                end else if (rx_count == 0) begin
                    push_res(STS_NONE, '0, '0, 1'b1);
                    rx_clear();
                end else begin
                    for (int i = 0; i < rx_count; i++)
                        push_res(STS_FRAME, rx_store[i], rx_count, i == rx_count - 1);
                    rx_clear();
                end
            end
            default: ;
        endcase
    endfunction

    // Offer one item, wait for its handshake, then log what it owes.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b,
                             input logic [TIME_W-1:0] t, input bit use_typed = 1'b0,
                             input t_status typed_st = STS_NONE);
        t_rx_result r;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.command  <= cmd;
        in_if.rx_byte  <= b;
        in_if.now_time <= t;
        do @(posedge i_clk); while (!in_if.ready);
        rx_predict(cmd, b, t);
        if (use_typed) begin
            r.status = typed_st;
            r.fbyte  = '0;
            r.flen   = '0;
            r.last   = 1'b1;
            rx_expect.push_back(r);
        end else begin
            foreach (poll_res[i]) rx_expect.push_back(poll_res[i]);
        end
        if (cmd != CMD_UNUSED) items_sent++;
    endtask

    // Stop offering and let every owed result come out.
    task automatic drain_rx();
        in_if.valid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && rx_expect.size() != 0; n++)
            @(posedge i_clk);
        repeat (DRAIN_EXTRA) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_GAP: gap_ms  = data[GAP_W-1:0];
            CFG_CAP: cap_len = data[CNT_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Well-formed frame: bytes, optionally an early poll, then a poll
    // after the gap. Unclean frames may end in a discard instead.
    task automatic rx_frame_seq(input int nbytes, input bit clean);
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] t_prev;
        int roll;
        t      = $urandom();
        t_prev = t;
        for (int i = 0; i < nbytes; i++) begin
            send_item(CMD_BYTE, 8'($urandom_range(0, 255)), t);
            t_prev = t;
            if (!clean && gap_ms != 0 && $urandom_range(0, 7) == 0)
                send_item(CMD_POLL, 8'($urandom_range(0, 255)),
                          t + $urandom_range(0, gap_ms - 1));
            t = t + $urandom_range(0, gap_ms);
        end
        roll = $urandom_range(0, 9);
        if (!clean && roll == 0)
            send_item(CMD_DISCARD, 8'($urandom_range(0, 255)), $urandom());
        else if (roll == 1)
            // elapsed time anywhere up to the top of the 32-bit range
            send_item(CMD_POLL, 8'($urandom_range(0, 255)),
                      t_prev + gap_ms + $urandom_range(0, 32'hFFFF_0000));
        else
            send_item(CMD_POLL, 8'($urandom_range(0, 255)),
                      t_prev + gap_ms + $urandom_range(0, 3));
    endtask

    // Result sink: random short stalls, plus one long hold-off on request.
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 2);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Scoreboard: each result transaction against the oldest expectation.
    always @(posedge i_clk) begin
        t_rx_result e;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (rx_expect.size() == 0) begin
                $error("result with nothing expected: status %0d byte %0h len %0d last %0b",
                       out_if.status, out_if.frame_byte, out_if.frame_len, out_if.last);
                errors++;
            end else begin
                e = rx_expect.pop_front();
                if (out_if.status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, out_if.status);
                    errors++;
                end
                if (out_if.frame_byte !== e.fbyte) begin
                    $error("frame_byte: expected %0h, got %0h", e.fbyte, out_if.frame_byte);
                    errors++;
                end
                if (out_if.frame_len !== e.flen) begin
                    $error("frame_len: expected %0d, got %0d", e.flen, out_if.frame_len);
                    errors++;
                end
                if (out_if.last !== e.last) begin
                    $error("last: expected %0b, got %0b", e.last, out_if.last);
                    errors++;
                end
            end
        end
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [GAP_W-1:0] gap_set [NUM_PHASES];
        logic [CNT_W-1:0] cap_set [NUM_PHASES];
        int phase_end;
        int roll;

        errors     = 0;
        items_sent = 0;
        idle_en    = 1'b1;
        hold_req   = 1'b0;
        gap_ms     = GAP_RESET;
        cap_len    = CAP_RESET;
        rx_clear();

        in_if.valid    <= 1'b0;
        in_if.command  <= CMD_BYTE;
        in_if.rx_byte  <= '0;
        in_if.now_time <= '0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_GAP;
        i_cfg_data     <= '0;
        i_rst_n        <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset register values.
        foreach (dir_tab[r]) begin
            for (int k = 0; k < dir_tab[r].reps; k++)
                send_item(dir_tab[r].cmd, BYTE_W'(dir_tab[r].b + k), dir_tab[r].t,
                          dir_tab[r].typed, dir_tab[r].st);
        end

        // Register settings per random phase, extremes included.
        // Phase 0 (gap 0) also carries the long receiver hold-off.
        gap_set = '{16'd0, 16'hFFFF, 16'd2, 16'($urandom_range(1, 12)), 16'd7, 16'd4};
        cap_set = '{7'd64, 7'd0, 7'd1, 7'($urandom_range(0, 64)), 7'd20, 7'd64};

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_rx();
            idle_en = (p != NUM_PHASES - 1);    // final phase runs back to back
            cfg_write(CFG_GAP, CFG_DATA_W'(gap_set[p]));
            cfg_write(CFG_CAP, CFG_DATA_W'(cap_set[p]));
            if (p == 0) begin
                // long frame streams into a stalled sink; sender keeps offering
                hold_req = 1'b1;
                rx_frame_seq(30, 1'b1);
                rx_frame_seq(3, 1'b1);
            end
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    rx_frame_seq($urandom_range(1, 6), 1'b0);
                else if (roll < 85)
                    rx_frame_seq($urandom_range(7, 20), 1'b0);
                else if (roll < 92)
                    rx_frame_seq(0, 1'b0);
                else if (roll < 97)
                    // noise: any command, unrelated time stamps
                    repeat ($urandom_range(1, 3))
                        send_item(CMD_W'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                  $urandom());
                else
                    rx_frame_seq($urandom_range(58, 66), 1'b0);
            end
        end

        drain_rx();
        if (rx_expect.size() != 0) begin
            $error("%0d expected results never arrived", rx_expect.size());
            errors++;
        end
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
hdl/mrtu_pkg.sv
hdl/mrtu_stream_if.sv
hdl/mrtu_ram.sv
hdl/mrtu_datapath.sv
hdl/mrtu_ctrl.sv
hdl/modbus_rtu_frame_gap_receiver.sv
dv/modbus_rtu_frame_gap_receiver_tb.sv
